// ===== hw/rtl/kte_pkg.sv =====
`timescale 1ns / 1ps

package kte_pkg;

    // Default saturation limit for the repeat count.
    localparam int MAX_REPEAT_DEF = 8;

    // Longest sequence produced for one repeat (ESC [ 2 4 ; 8 ~).
    localparam int SEQ_MAX = 7;
    localparam int SEQ_CNT_W = $clog2(SEQ_MAX + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic build;
        logic shift;
    } kte_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go;
        logic seq_empty;
        logic seq_last;
        logic rep_last;
    } kte_status_t;

endpackage

// ===== hw/rtl/kte_dp.sv =====
`timescale 1ns / 1ps

module kte_dp #(
    parameter int MaxRepeat = kte_pkg::MAX_REPEAT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kte_pkg::kte_cmd_t    cmd,
    output kte_pkg::kte_status_t status,
    input  logic                 key_down,
    input  logic [7:0]           virtual_key,
    input  logic [15:0]          char_unit,
    input  logic [8:0]           control_state,
    input  logic [3:0]           repeat_count,
    output logic [7:0]           out_byte,
    output logic                 last_byte
);

    localparam int RepW = $clog2(MaxRepeat + 1);
    localparam int CntW = kte_pkg::SEQ_CNT_W;
    localparam int SeqN = kte_pkg::SEQ_MAX;

    localparam logic [7:0] VK_BACK   = 8'h08;
    localparam logic [7:0] VK_SPC    = 8'h20;
    localparam logic [7:0] VK_PGUP   = 8'h21;
    localparam logic [7:0] VK_NEXT   = 8'h22;
    localparam logic [7:0] VK_END    = 8'h23;
    localparam logic [7:0] VK_HOME   = 8'h24;
    localparam logic [7:0] VK_LEFT   = 8'h25;
    localparam logic [7:0] VK_UP     = 8'h26;
    localparam logic [7:0] VK_RGT    = 8'h27;
    localparam logic [7:0] VK_DOWN   = 8'h28;
    localparam logic [7:0] VK_INS    = 8'h2D;
    localparam logic [7:0] VK_DEL    = 8'h2E;
    localparam logic [7:0] VK_F1     = 8'h70;
    localparam logic [7:0] VK_F4     = 8'h73;
    localparam logic [7:0] VK_F5     = 8'h74;
    localparam logic [7:0] VK_F12    = 8'h7B;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;

    typedef enum logic [2:0] {
        K_CHAR,
        K_LETTER,
        K_SS3,
        K_TILDE,
        K_BACK
    } key_kind_t;

    // Tilde numbers of F5..F12 as two decimal digits.
    function automatic logic [7:0] fkey_num(input logic [2:0] f);
        logic [7:0] r;
        case (f)
            3'd0:    r = 8'h15;
            3'd1:    r = 8'h17;
            3'd2:    r = 8'h18;
            3'd3:    r = 8'h19;
            3'd4:    r = 8'h20;
            3'd5:    r = 8'h21;
            3'd6:    r = 8'h23;
            default: r = 8'h24;
        endcase
        return r;
    endfunction

    logic [7:0]      vk_reg;
    logic [15:0]     unit_reg;
    logic            alt_reg;
    logic            ctrl_reg;
    logic            shift_key_reg;
    logic [15:0]     pending_reg;
    logic [15:0]     pending_next;
    logic [RepW-1:0] rep_reg;
    logic [RepW-1:0] rep_sat;
    logic [CntW-1:0] cnt_reg;
    logic [7:0]      buf_reg [SeqN];

    key_kind_t       kind;
    logic [7:0]      letter;
    logic [7:0]      num_bcd;
    logic            modified;
    logic [7:0]      mod_digit;
    logic [20:0]     cp;
    logic [7:0]      seq [SeqN];
    logic [CntW-1:0] idx;

    assign modified  = alt_reg | ctrl_reg | shift_key_reg;
    assign mod_digit = CH_ONE + {5'd0, ctrl_reg, alt_reg, shift_key_reg};

    always_comb
    begin
        if (32'(repeat_count) > 32'(MaxRepeat))
        begin
            rep_sat = RepW'(MaxRepeat);
        end
        else
        begin
            rep_sat = RepW'(repeat_count);
        end
    end

    // Key class and the letter or number that goes with it.
    always_comb
    begin
        kind    = K_CHAR;
        letter  = CH_P;
        num_bcd = 8'h00;
        case (vk_reg) inside
            VK_UP:     begin kind = K_LETTER; letter = 8'h41; end
            VK_DOWN:   begin kind = K_LETTER; letter = 8'h42; end
            VK_RGT:    begin kind = K_LETTER; letter = 8'h43; end
            VK_LEFT:   begin kind = K_LETTER; letter = 8'h44; end
            VK_HOME:   begin kind = K_LETTER; letter = 8'h48; end
            VK_END:    begin kind = K_LETTER; letter = 8'h46; end
            VK_INS:    begin kind = K_TILDE; num_bcd = 8'h02; end
            VK_DEL:    begin kind = K_TILDE; num_bcd = 8'h03; end
            VK_PGUP:   begin kind = K_TILDE; num_bcd = 8'h05; end
            VK_NEXT:   begin kind = K_TILDE; num_bcd = 8'h06; end
            VK_BACK:   kind = K_BACK;
            [VK_F1:VK_F4]:
            begin
                kind   = modified ? K_LETTER : K_SS3;
                letter = CH_P + {6'd0, vk_reg[1:0]};
            end
            [VK_F5:VK_F12]:
            begin
                kind    = K_TILDE;
                num_bcd = fkey_num(3'(vk_reg - VK_F5));
            end
            default:   kind = K_CHAR;
        endcase
    end

    // A low surrogate after a stored high one forms one code point.
    always_comb
    begin
        if (unit_reg >= 16'hDC00 && unit_reg < 16'hE000 && pending_reg != 16'h0000)
        begin
            cp = 21'h10000 + {1'b0, pending_reg[9:0], unit_reg[9:0]};
        end
        else
        begin
            cp = {5'd0, unit_reg};
        end
    end

    // Byte sequence for one repeat, assembled front to back.
    always_comb
    begin
        for (int i = 0; i < SeqN; i++)
        begin
            seq[i] = 8'h00;
        end
        idx          = '0;
        pending_next = pending_reg;
        case (kind)
            K_LETTER, K_TILDE:
            begin
                seq[idx] = CH_ESC;  idx = idx + 1'b1;
                seq[idx] = CH_LBRK; idx = idx + 1'b1;
                if (kind == K_LETTER)
                begin
                    if (modified)
                    begin
                        seq[idx] = CH_ONE;    idx = idx + 1'b1;
                        seq[idx] = CH_SEMI;   idx = idx + 1'b1;
                        seq[idx] = mod_digit; idx = idx + 1'b1;
                    end
                    seq[idx] = letter; idx = idx + 1'b1;
                end
                else
                begin
                    if (num_bcd[7:4] != 4'd0)
                    begin
                        seq[idx] = CH_ZERO + {4'd0, num_bcd[7:4]}; idx = idx + 1'b1;
                    end
                    seq[idx] = CH_ZERO + {4'd0, num_bcd[3:0]}; idx = idx + 1'b1;
                    if (modified)
                    begin
                        seq[idx] = CH_SEMI;   idx = idx + 1'b1;
                        seq[idx] = mod_digit; idx = idx + 1'b1;
                    end
                    seq[idx] = CH_TILDE; idx = idx + 1'b1;
                end
            end
            K_SS3:
            begin
                seq[idx] = CH_ESC; idx = idx + 1'b1;
                seq[idx] = CH_O;   idx = idx + 1'b1;
                seq[idx] = letter; idx = idx + 1'b1;
            end
            K_BACK:
            begin
                if (alt_reg)
                begin
                    seq[idx] = CH_ESC; idx = idx + 1'b1;
                end
                seq[idx] = CH_DEL; idx = idx + 1'b1;
            end
            default:
            begin
                if (unit_reg == 16'h0000)
                begin
                    if (vk_reg == VK_SPC && ctrl_reg)
                    begin
                        seq[idx] = CH_NUL; idx = idx + 1'b1;
                    end
                end
                else if (unit_reg >= 16'hD800 && unit_reg < 16'hDC00)
                begin
                    pending_next = unit_reg;
                end
                else
                begin
                    if (cp[20:16] != 5'd0)
                    begin
                        pending_next = 16'h0000;
                    end
                    if (alt_reg && !ctrl_reg)
                    begin
                        seq[idx] = CH_ESC; idx = idx + 1'b1;
                    end
                    if (cp < 21'h80)
                    begin
                        seq[idx] = cp[7:0]; idx = idx + 1'b1;
                    end
                    else if (cp < 21'h800)
                    begin
                        seq[idx] = {3'b110, cp[10:6]}; idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[5:0]};   idx = idx + 1'b1;
                    end
                    else if (cp < 21'h10000)
                    begin
                        seq[idx] = {4'b1110, cp[15:12]}; idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[11:6]};    idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[5:0]};     idx = idx + 1'b1;
                    end
                    else
                    begin
                        seq[idx] = {5'b11110, cp[20:18]}; idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[17:12]};    idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[11:6]};     idx = idx + 1'b1;
                        seq[idx] = {2'b10, cp[5:0]};      idx = idx + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            rep_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rep_reg <= rep_sat;
            end
            if (cmd.build)
            begin
                cnt_reg     <= idx;
                pending_reg <= pending_next;
            end
            if (cmd.shift)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    rep_reg <= rep_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vk_reg        <= virtual_key;
            unit_reg      <= char_unit;
            alt_reg       <= |control_state[1:0];
            ctrl_reg      <= |control_state[3:2];
            shift_key_reg <= control_state[4];
        end
        if (cmd.build)
        begin
            buf_reg <= seq;
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < SeqN - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
            buf_reg[SeqN - 1] <= 8'h00;
        end
    end

    assign status.go        = key_down && (repeat_count != 4'd0);
    assign status.seq_empty = (idx == '0);
    assign status.seq_last  = (cnt_reg == CntW'(1));
    assign status.rep_last  = (rep_reg == RepW'(1));

    assign out_byte  = buf_reg[0];
    assign last_byte = status.seq_last && status.rep_last;

endmodule

// ===== hw/rtl/kte_ctrl.sv =====
`timescale 1ns / 1ps

module kte_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  kte_pkg::kte_status_t status,
    output kte_pkg::kte_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready_reg;
    assign cmd.build   = (state_reg == S_BUILD);
    assign cmd.shift   = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && status.go)
                    begin
                        state_reg    <= S_BUILD;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_BUILD:
                begin
                    // An empty sequence is empty for every repeat.
                    if (status.seq_empty)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg     <= S_EMIT;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready && status.seq_last)
                    begin
                        out_valid_reg <= 1'b0;
                        if (status.rep_last)
                        begin
                            state_reg    <= S_IDLE;
                            in_ready_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_BUILD;
                        end
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready_reg)
        else $error("input taken while bytes are still pending");

    a_empty_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD && status.seq_empty) |=> in_ready_reg)
        else $error("empty sequence did not return to idle");

    a_silent_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready_reg && !status.go) |=> (in_ready_reg && !out_valid_reg))
        else $error("silent item started work");

endmodule

// ===== hw/rtl/key_event_to_terminal_bytes.sv =====
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     key_down, virtual_key, char_unit,
//                                   control_state, repeat_count
// output    out_valid / out_ready   out_byte, last_byte
//
// One item is taken with each input handshake. Each repeat then assembles
// its byte sequence in a small shift buffer and shifts the bytes out in order.
// An item that gives no bytes returns the block to idle with no output.
// The block takes a new item only once the last byte of the previous one
// has been delivered. A stalled output holds the byte in place.
// Reset clears the controller and the stored high surrogate.

module key_event_to_terminal_bytes #(
    parameter int MaxRepeat = kte_pkg::MAX_REPEAT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        key_down,
    input  logic [7:0]  virtual_key,
    input  logic [15:0] char_unit,
    input  logic [8:0]  control_state,
    input  logic [3:0]  repeat_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    kte_pkg::kte_cmd_t    cmd;
    kte_pkg::kte_status_t status;

    // The controller sequences capture, per-repeat assembly and byte output.
    kte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the event, the surrogate state and the byte buffer.
    kte_dp #(
        .MaxRepeat (MaxRepeat)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .key_down      (key_down),
        .virtual_key   (virtual_key),
        .char_unit     (char_unit),
        .control_state (control_state),
        .repeat_count  (repeat_count),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

    // After the final byte of an item the output goes quiet and input opens.
    a_item_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> (!out_valid && in_ready))
        else $error("item did not finish after its last byte");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Repeat counts above this limit are clipped by the block.
    localparam int MAX_REPEAT = kte_pkg::MAX_REPEAT_DEF;

    // The run is cut short here. The slowest correct run is around 120 items
    // of up to 56 bytes each, with bytes held back by receiver stalls, so
    // this leaves a wide margin.
    localparam int CYCLE_LIMIT = 500000;

    // Once the last byte has arrived, we watch a little longer for stray output.
    localparam int TAIL_CYCLES = 100;

    // Random key presses with a nonzero repeat count (releases and zero repeats
    // are not counted).
    localparam int RANDOM_EVENTS = 82;

    // Virtual key codes that have a sequence of their own.
    localparam logic [7:0] VK_BACK   = 8'h08;
    localparam logic [7:0] VK_SPC    = 8'h20;
    localparam logic [7:0] VK_PGUP   = 8'h21;
    localparam logic [7:0] VK_NEXT   = 8'h22;
    localparam logic [7:0] VK_END    = 8'h23;
    localparam logic [7:0] VK_HOME   = 8'h24;
    localparam logic [7:0] VK_LEFT   = 8'h25;
    localparam logic [7:0] VK_UP     = 8'h26;
    localparam logic [7:0] VK_RGT    = 8'h27;
    localparam logic [7:0] VK_DOWN   = 8'h28;
    localparam logic [7:0] VK_INS    = 8'h2D;
    localparam logic [7:0] VK_DEL    = 8'h2E;
    localparam logic [7:0] VK_F1     = 8'h70;
    localparam logic [7:0] VK_F4     = 8'h73;
    localparam logic [7:0] VK_F5     = 8'h74;
    localparam logic [7:0] VK_F12    = 8'h7B;
    // A key with no sequence of its own, used for typed characters.
    localparam logic [7:0] VK_KEY_A  = 8'h41;

    // Modifier bits of control_state.
    localparam logic [8:0] MOD_NONE  = 9'h000;
    localparam logic [8:0] MOD_RALT  = 9'h001;
    localparam logic [8:0] MOD_LALT  = 9'h002;
    localparam logic [8:0] MOD_RCTRL = 9'h004;
    localparam logic [8:0] MOD_LCTRL = 9'h008;
    localparam logic [8:0] MOD_SHIFT = 9'h010;
    localparam logic [8:0] MOD_ALL   = 9'h01F;

    // Control bytes and UTF-16 surrogate ranges.
    localparam logic [7:0]  ESC_CHAR   = 8'h1B;
    localparam logic [7:0]  DEL_CHAR   = 8'h7F;
    localparam logic [7:0]  NUL_CHAR   = 8'h00;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;
    localparam logic [15:0] SURR_LIMIT = 16'hE000;

    // One keyboard event on its way to the block. When hold_until_quiet is
    // set, the sender waits until every expected byte has come back before
    // it offers this item.
    typedef struct packed {
        logic        down;
        logic [7:0]  vkey;
        logic [15:0] unit;
        logic [8:0]  mods;
        logic [3:0]  reps;
        logic        hold_until_quiet;
    } key_event_t;

    // One byte that the block should deliver.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } term_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        key_down = 1'b0;
    logic [7:0]  virtual_key = '0;
    logic [15:0] char_unit = '0;
    logic [8:0]  control_state = '0;
    logic [3:0]  repeat_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last_byte;

    key_event_t key_events[$];     // items not yet offered to the block
    term_byte_t expected_bytes[$]; // bytes predicted but not yet seen
    logic [7:0] seq_bytes[$];      // scratch buffer for one event

    // This is the predictor's copy of the stored high surrogate.
    logic [15:0] held_high_surrogate = '0;

    int presented_count = 0;
    int accepted_count = 0;
    int total_events = 0;
    int byte_count = 0;
    int mismatches = 0;
    int cycle_count = 0;

    int idle_pct;
    int stall_pct;

    key_event_to_terminal_bytes DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_down      (key_down),
        .virtual_key   (virtual_key),
        .char_unit     (char_unit),
        .control_state (control_state),
        .repeat_count  (repeat_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

    // The clock has a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // This writes a value of up to two decimal digits, with no leading zero.
    function automatic void emit_decimal(input int unsigned v);
        if (v >= 10)
            seq_bytes.push_back(8'("0" + (v / 10) % 10));
        seq_bytes.push_back(8'("0" + v % 10));
    endfunction

    // This writes ESC [ letter, or ESC [ 1 ; m letter when a modifier is held.
    function automatic void emit_csi_letter(input logic [7:0] letter, input int unsigned m);
        seq_bytes.push_back(ESC_CHAR);
        seq_bytes.push_back("[");
        if (m > 1)
        begin
            seq_bytes.push_back("1");
            seq_bytes.push_back(";");
            emit_decimal(m);
        end
        seq_bytes.push_back(letter);
    endfunction

    // This writes ESC [ n ~, or ESC [ n ; m ~ when a modifier is held.
    function automatic void emit_csi_tilde(input int unsigned num, input int unsigned m);
        seq_bytes.push_back(ESC_CHAR);
        seq_bytes.push_back("[");
        emit_decimal(num);
        if (m > 1)
        begin
            seq_bytes.push_back(";");
            emit_decimal(m);
        end
        seq_bytes.push_back("~");
    endfunction

    // This works out the bytes of one accepted event and appends them to
    // expected_bytes. The last one carries the end-of-event flag. It also
    // updates the stored high surrogate just as the block should.
    function automatic void encode_key_event(input key_event_t ev);
        logic        alt;
        logic        ctrl;
        logic        shift;
        logic        special;
        int unsigned m;
        int unsigned reps;
        int unsigned fidx;
        int unsigned cp;
        term_byte_t  tb;

        alt   = |(ev.mods & (MOD_RALT | MOD_LALT));
        ctrl  = |(ev.mods & (MOD_RCTRL | MOD_LCTRL));
        shift = |(ev.mods & MOD_SHIFT);
        m = 1 + (shift ? 1 : 0) + (alt ? 2 : 0) + (ctrl ? 4 : 0);
        seq_bytes.delete();

        if (ev.down)
        begin
            reps = (ev.reps > MAX_REPEAT) ? MAX_REPEAT : ev.reps;
            for (int r = 0; r < reps; r++)
            begin
                special = 1'b1;
                case (ev.vkey)
                    VK_UP:     emit_csi_letter("A", m);
                    VK_DOWN:   emit_csi_letter("B", m);
                    VK_RGT:    emit_csi_letter("C", m);
                    VK_LEFT:   emit_csi_letter("D", m);
                    VK_HOME:   emit_csi_letter("H", m);
                    VK_END:    emit_csi_letter("F", m);
                    VK_INS:    emit_csi_tilde(2, m);
                    VK_DEL:    emit_csi_tilde(3, m);
                    VK_PGUP:   emit_csi_tilde(5, m);
                    VK_NEXT:   emit_csi_tilde(6, m);
                    VK_BACK:
                    begin
                        if (alt)
                            seq_bytes.push_back(ESC_CHAR);
                        seq_bytes.push_back(DEL_CHAR);
                    end
                    default:
                    begin
                        if (ev.vkey >= VK_F1 && ev.vkey <= VK_F4)
                        begin
                            if (m > 1)
                                emit_csi_letter(8'("P" + (ev.vkey - VK_F1)), m);
                            else
                            begin
                                seq_bytes.push_back(ESC_CHAR);
                                seq_bytes.push_back("O");
                                seq_bytes.push_back(8'("P" + (ev.vkey - VK_F1)));
                            end
                        end
                        else if (ev.vkey >= VK_F5 && ev.vkey <= VK_F12)
                        begin
                            // F5 to F12 map to 15, 17..21, 23, 24: the numbers
                            // skip 16 after F5 and 22 after F10.
                            fidx = ev.vkey - VK_F5;
                            emit_csi_tilde(15 + fidx + (fidx >= 1 ? 1 : 0)
                                           + (fidx >= 6 ? 1 : 0), m);
                        end
                        else
                            special = 1'b0;
                    end
                endcase

                if (!special)
                begin
                    if (ev.unit == 16'h0000)
                    begin
                        // With no character, only Ctrl+Space produces anything.
                        if (ev.vkey == VK_SPC && ctrl)
                            seq_bytes.push_back(NUL_CHAR);
                    end
                    else if (ev.unit >= HIGH_SURR && ev.unit < LOW_SURR)
                        held_high_surrogate = ev.unit;
                    else
                    begin
                        cp = ev.unit;
                        if (ev.unit >= LOW_SURR && ev.unit < SURR_LIMIT
                            && held_high_surrogate != 16'h0000)
                        begin
                            cp = 32'h10000 + ((32'(held_high_surrogate) - HIGH_SURR) << 10)
                                 + (32'(ev.unit) - LOW_SURR);
                            held_high_surrogate = '0;
                        end
                        if (alt && !ctrl)
                            seq_bytes.push_back(ESC_CHAR);
                        if (cp < 32'h80)
                            seq_bytes.push_back(8'(cp));
                        else if (cp < 32'h800)
                        begin
                            seq_bytes.push_back(8'(32'hC0 | (cp >> 6)));
                            seq_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
                        end
                        else if (cp < 32'h10000)
                        begin
                            seq_bytes.push_back(8'(32'hE0 | (cp >> 12)));
                            seq_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
                            seq_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
                        end
                        else
                        begin
                            seq_bytes.push_back(8'(32'hF0 | (cp >> 18)));
                            seq_bytes.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
                            seq_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
                            seq_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
                        end
                    end
                end
            end
        end

        foreach (seq_bytes[k])
        begin
            tb.value = seq_bytes[k];
            tb.last  = (k == seq_bytes.size() - 1);
            expected_bytes.push_back(tb);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_event(input logic down, input logic [7:0] vkey,
                                        input logic [15:0] unit, input logic [8:0] mods,
                                        input logic [3:0] reps, input logic hold);
        key_event_t ev;
        ev.down = down;
        ev.vkey = vkey;
        ev.unit = unit;
        ev.mods = mods;
        ev.reps = reps;
        ev.hold_until_quiet = hold;
        key_events.push_back(ev);
    endfunction

    // Idling follows the position in the item stream. Each phase of 24 items
    // gives in turn: no idling, a sender that idles, a receiver that stalls,
    // and then both at a lower rate.
    always_comb
    begin
        case ((presented_count / 24) % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 45; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    end

    // The driver changes the inputs on the falling edge. A new item is
    // offered only once the previous one has been accepted, so valid and the
    // payload stay steady while the block holds off. Each signal is
    // assigned once here per edge.
    always @(negedge clk)
    begin : drive_inputs
        logic       offer;
        key_event_t ev;

        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (accepted_count == presented_count)
            begin
                offer = 1'b0;
                if (key_events.size() != 0 && $urandom_range(99) >= idle_pct)
                    offer = !key_events[0].hold_until_quiet || expected_bytes.size() == 0;
                if (offer)
                begin
                    ev = key_events.pop_front();
                    key_down      <= ev.down;
                    virtual_key   <= ev.vkey;
                    char_unit     <= ev.unit;
                    control_state <= ev.mods;
                    repeat_count  <= ev.reps;
                    presented_count <= presented_count + 1;
                end
                in_valid <= offer;
            end
        end
    end

    // The monitor samples on the rising edge. An accepted item is predicted at
    // once. Each delivered byte is then checked against the oldest
    // prediction.
    always @(posedge clk)
    begin : check_outputs
        key_event_t ev;
        term_byte_t want;

        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                ev.down = key_down;
                ev.vkey = virtual_key;
                ev.unit = char_unit;
                ev.mods = control_state;
                ev.reps = repeat_count;
                ev.hold_until_quiet = 1'b0;
                encode_key_event(ev);
                accepted_count <= accepted_count + 1;
            end

            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Byte %0d: got %02h last %0b with nothing expected",
                                 byte_count, out_byte, last_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value || last_byte !== want.last)
                    begin
                        if (mismatches < 10)
                            $display("Byte %0d: expected %02h last %0b, got %02h last %0b",
                                     byte_count, want.value, want.last, out_byte, last_byte);
                        mismatches++;
                    end
                end
                byte_count++;
            end
        end
    end

    // A watchdog stops a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int          counted;
        int          pick;
        logic [7:0]  vkey;
        logic [15:0] unit;
        logic [3:0]  reps;

        // Directed items. These cover the cursor, editing and Backspace keys and
        // F1, F4, F5 and F12, with a spread of modifier values, the longest
        // possible event, the character cases and the surrogate handling.
        queue_event(1'b1, VK_UP,     16'h0000, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_DOWN,   16'h0000, MOD_SHIFT, 4'd2, 1'b0);
        queue_event(1'b1, VK_RGT,    16'h0000, MOD_RALT, 4'd1, 1'b0);
        queue_event(1'b1, VK_LEFT,   16'h0000, MOD_LCTRL, 4'd1, 1'b0);
        // The character is ignored here. Every modifier bit is set, the
        // unused upper bits as well.
        queue_event(1'b1, VK_HOME,   16'hFFFF, 9'h1FF, 4'd1, 1'b0);
        queue_event(1'b1, VK_END,    16'h0000, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_INS,    16'h0000, MOD_RCTRL, 4'd1, 1'b0);
        queue_event(1'b1, VK_DEL,    16'h0000, MOD_LALT | MOD_SHIFT, 4'd1, 1'b0);
        queue_event(1'b1, VK_PGUP,   16'h0000, MOD_RCTRL | MOD_SHIFT, 4'd1, 1'b0);
        queue_event(1'b1, VK_NEXT,   16'h0000, MOD_LALT | MOD_LCTRL, 4'd1, 1'b0);
        queue_event(1'b1, VK_BACK,   16'h0008, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_BACK,   16'h0008, MOD_LALT, 4'd2, 1'b0);
        queue_event(1'b1, VK_F1,     16'h0000, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_F4,     16'h0000, MOD_LCTRL, 4'd1, 1'b0);
        queue_event(1'b1, VK_F5,     16'h0000, MOD_NONE, 4'd1, 1'b0);
        // F12 with every modifier, eight times over: the longest event.
        queue_event(1'b1, VK_F12,    16'h0000, MOD_ALL, 4'd8, 1'b0);
        queue_event(1'b1, VK_SPC,    16'h0000, MOD_LCTRL, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'h0000, MOD_NONE, 4'd1, 1'b0);
        // A release and a zero repeat count give no bytes.
        queue_event(1'b0, VK_UP,     16'h0061, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'h0061, MOD_NONE, 4'd0, 1'b0);
        // Fifteen repeats are clipped to the limit.
        queue_event(1'b1, VK_KEY_A,  16'h0061, MOD_NONE, 4'd15, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'h0061, MOD_LALT, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'h0001, MOD_RALT | MOD_RCTRL, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'h00E9, MOD_SHIFT, 4'd1, 1'b0);
        // The sender lets everything drain first. A high surrogate is then
        // replaced by a second one, which joins the following low surrogate
        // into the highest code point. A lone low surrogate follows.
        queue_event(1'b1, VK_KEY_A,  HIGH_SURR, MOD_NONE, 4'd1, 1'b1);
        queue_event(1'b1, VK_KEY_A,  16'hDBFF, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  16'hDFFF, MOD_NONE, 4'd1, 1'b0);
        queue_event(1'b1, VK_KEY_A,  LOW_SURR, MOD_NONE, 4'd1, 1'b0);

        // Random items are mostly well-formed key presses with random
        // content, along with surrogate pairs, some releases and some noise.
        counted = 0;
        while (counted < RANDOM_EVENTS)
        begin
            reps = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 3));
            pick = $urandom_range(99);
            if (pick < 10)
                queue_event(1'b0, 8'($urandom), 16'($urandom), 9'($urandom_range(511)),
                            4'($urandom_range(15)), 1'b0);
            else if (pick < 45)
            begin
                case ($urandom_range(21))
                    0:       vkey = VK_BACK;
                    1:       vkey = VK_PGUP;
                    2:       vkey = VK_NEXT;
                    3:       vkey = VK_END;
                    4:       vkey = VK_HOME;
                    5:       vkey = VK_LEFT;
                    6:       vkey = VK_UP;
                    7:       vkey = VK_RGT;
                    8:       vkey = VK_DOWN;
                    9:       vkey = VK_INS;
                    10:      vkey = VK_DEL;
                    default: vkey = 8'(VK_F1 + $urandom_range(11));
                endcase
                queue_event(1'b1, vkey, 16'($urandom), 9'($urandom_range(511)), reps, 1'b0);
                counted += (reps != 0);
            end
            else if (pick < 85)
            begin
                vkey = 8'($urandom_range(8'h30, 8'h5A));
                case ($urandom_range(6))
                    0:       unit = 16'($urandom_range(1, 16'h7F));
                    1:       unit = 16'($urandom_range(16'h80, 16'h7FF));
                    2:       unit = 16'($urandom_range(16'h800, 16'hD7FF));
                    3:       unit = 16'($urandom_range(SURR_LIMIT, 16'hFFFF));
                    4:       unit = 16'($urandom_range(LOW_SURR, SURR_LIMIT - 1));
                    5:       unit = 16'h0000;
                    default:
                    begin
                        // A surrogate pair split over two items.
                        queue_event(1'b1, vkey, 16'($urandom_range(HIGH_SURR, LOW_SURR - 1)),
                                    9'($urandom_range(511)), 4'd1, 1'b0);
                        counted++;
                        unit = 16'($urandom_range(LOW_SURR, SURR_LIMIT - 1));
                    end
                endcase
                // Space is sometimes used so that Ctrl+Space is reached.
                if (unit == 16'h0000 && $urandom_range(1) == 1)
                    vkey = VK_SPC;
                queue_event(1'b1, vkey, unit, 9'($urandom_range(511)), reps, 1'b0);
                counted += (reps != 0);
            end
            else
            begin
                reps = 4'($urandom_range(15));
                queue_event(1'b1, 8'($urandom), 16'($urandom), 9'($urandom_range(511)),
                            reps, 1'b0);
                counted += (reps != 0);
            end
        end
        total_events = key_events.size();

        // Reset is held low at the start and released on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_events || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
